FILE: rtl/mfrp_pkg.sv
// Shared constants, types and register codes for the framed report parser.
package mfrp_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int REPORT_LEN  = 7;
    localparam int OUT_BYTES   = 7;

    localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
    localparam int GAP_MAX = (STORE_DEPTH > REPORT_LEN + 2) ? STORE_DEPTH : REPORT_LEN + 2;
    localparam int GAP_W   = $clog2(GAP_MAX + 1);

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_START_FIRST  = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_END_FIRST    = 2'd2;
    localparam logic [1:0] REG_END_SECOND   = 2'd3;

    localparam logic [7:0] START_FIRST_RST  = 8'h55;
    localparam logic [7:0] START_SECOND_RST = 8'hAA;
    localparam logic [7:0] END_FIRST_RST    = 8'h0D;
    localparam logic [7:0] END_SECOND_RST   = 8'h0A;

    localparam logic [OUT_BYTES-1:0][7:0] REPORT_RST =
        {8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 8'd0};

    typedef struct packed {
        logic [7:0] start_first;
        logic [7:0] start_second;
        logic [7:0] end_first;
        logic [7:0] end_second;
    } mark_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic accepted;
        logic bad_length;
        logic dropped;
    } seq_stat_t;

    typedef logic [REPORT_LEN-1:0][7:0] pay_t;

endpackage

FILE: rtl/mfrp_store.sv
// Byte store with one write port and one registered read port.
module mfrp_store (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [mfrp_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic [mfrp_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                  rdata
);

    logic [7:0] mem [0:mfrp_pkg::STORE_DEPTH-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mfrp_seq.sv
// Sequencer that appends a byte, scans the store for a frame and compacts it.
module mfrp_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [7:0]            rx_byte,
    input  mfrp_pkg::mark_t       marks,
    output mfrp_pkg::seq_stat_t   stat,
    output mfrp_pkg::pay_t        payload
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COPY} state_t;

    localparam logic [mfrp_pkg::GAP_W-1:0] GAP_MIN = mfrp_pkg::GAP_W'(2);
    localparam logic [mfrp_pkg::GAP_W-1:0] GAP_ACC =
        mfrp_pkg::GAP_W'(mfrp_pkg::REPORT_LEN + 2);
    localparam logic [mfrp_pkg::CNT_W-1:0] FULL_CNT =
        mfrp_pkg::CNT_W'(mfrp_pkg::STORE_DEPTH);

    state_t                       state_reg, state_next;
    logic [mfrp_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [mfrp_pkg::CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mfrp_pkg::CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [mfrp_pkg::CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic                         found_reg, found_next;
    logic [mfrp_pkg::GAP_W-1:0]   gap_reg, gap_next;
    logic [7:0]                   hist_reg [0:mfrp_pkg::REPORT_LEN];
    logic [7:0]                   hist_next [0:mfrp_pkg::REPORT_LEN];
    mfrp_pkg::pay_t               pay_reg, pay_next;
    logic                         done_reg, done_next;
    logic                         acc_reg, acc_next;
    logic                         bad_reg, bad_next;
    logic                         drop_reg, drop_next;

    logic                         mem_we;
    logic [mfrp_pkg::ADDR_W-1:0]  mem_waddr;
    logic [7:0]                   mem_wdata;
    logic [7:0]                   cur;
    logic [7:0]                   cmp_first;
    logic [7:0]                   cmp_second;
    logic                         pair_ok;
    logic                         pair_hit;
    logic                         start_hit;
    logic                         end_hit;
    logic [mfrp_pkg::GAP_W-1:0]   gap_now;
    logic                         more;

    mfrp_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_ptr_reg[mfrp_pkg::ADDR_W-1:0]),
        .rdata (cur)
    );

    // One pair compare serves both searches: start mark first, then end mark.
    always_comb begin
        cmp_first  = found_reg ? marks.end_first  : marks.start_first;
        cmp_second = found_reg ? marks.end_second : marks.start_second;
        pair_ok    = (state_reg == ST_SCAN) && rd_vld_reg && (rd_idx_reg != '0);
        pair_hit   = (hist_reg[0] == cmp_first) && (cur == cmp_second);
        gap_now    = gap_reg + mfrp_pkg::GAP_W'(1);
        start_hit  = pair_ok && !found_reg && pair_hit;
        end_hit    = pair_ok && found_reg && (gap_now >= GAP_MIN) && pair_hit;
        more       = rd_ptr_reg < fill_reg;
    end

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_idx_next = rd_idx_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_vld_next = 1'b0;
        found_next  = found_reg;
        gap_next    = gap_reg;
        hist_next   = hist_reg;
        pay_next    = pay_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        bad_next    = bad_reg;
        drop_next   = drop_reg;
        mem_we      = 1'b0;
        mem_waddr   = fill_reg[mfrp_pkg::ADDR_W-1:0];
        mem_wdata   = rx_byte;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (fill_reg != FULL_CNT) begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + mfrp_pkg::CNT_W'(1);
                    end
                    drop_next   = (fill_reg == FULL_CNT);
                    acc_next    = 1'b0;
                    bad_next    = 1'b0;
                    rd_ptr_next = '0;
                    found_next  = 1'b0;
                    gap_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg) begin
                    hist_next[0] = cur;
                    for (int k = 1; k <= mfrp_pkg::REPORT_LEN; k++) begin
                        hist_next[k] = hist_reg[k-1];
                    end
                    if (start_hit) begin
                        found_next = 1'b1;
                        gap_next   = '0;
                    end else if (found_reg) begin
                        gap_next = gap_now;
                    end
                end
                if (end_hit) begin
                    acc_next = (gap_now == GAP_ACC);
                    bad_next = (gap_now != GAP_ACC);
                    for (int k = 0; k < mfrp_pkg::REPORT_LEN; k++) begin
                        pay_next[k] = hist_reg[mfrp_pkg::REPORT_LEN-k];
                    end
                    rd_ptr_next = rd_idx_reg + mfrp_pkg::CNT_W'(1);
                    wr_ptr_next = '0;
                    state_next  = ST_COPY;
                end else if (more) begin
                    rd_ptr_next = rd_ptr_reg + mfrp_pkg::CNT_W'(1);
                    rd_idx_next = rd_ptr_reg;
                    rd_vld_next = 1'b1;
                end else if (!rd_vld_reg) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COPY: begin
                if (rd_vld_reg) begin
                    mem_we      = 1'b1;
                    mem_waddr   = wr_ptr_reg[mfrp_pkg::ADDR_W-1:0];
                    mem_wdata   = cur;
                    wr_ptr_next = wr_ptr_reg + mfrp_pkg::CNT_W'(1);
                end
                if (more) begin
                    rd_ptr_next = rd_ptr_reg + mfrp_pkg::CNT_W'(1);
                    rd_vld_next = 1'b1;
                end else if (!rd_vld_reg) begin
                    fill_next  = wr_ptr_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
        rd_ptr_reg <= rd_ptr_next;
        rd_idx_reg <= rd_idx_next;
        wr_ptr_reg <= wr_ptr_next;
        gap_reg    <= gap_next;
        hist_reg   <= hist_next;
        pay_reg    <= pay_next;
        acc_reg    <= acc_next;
        bad_reg    <= bad_next;
        drop_reg   <= drop_next;
    end

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.done       = done_reg;
    assign stat.accepted   = acc_reg;
    assign stat.bad_length = bad_reg;
    assign stat.dropped    = drop_reg;
    assign payload         = pay_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("Fill count exceeds the store depth.");

    a_copy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> found_reg)
        else $error("Compaction started without a start mark.");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("Completion pulse outside the idle state.");

endmodule

FILE: rtl/magic_framed_report_parser.sv
// Top level: register port, transfer handshakes, held report and result register.
// An accepted byte is written at its accepting edge unless the store is full, when it is dropped;
// then the scan, and after a frame the compaction, read one store entry per cycle.
// The next byte is taken only once the sequencer is idle again and the result slot is free.
// Reset (aresetn low at a clock edge) empties the store, restores the default marks and sets
// the report to 0,0,0,128,128,128,128; no clearing pass is needed.
module magic_framed_report_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mfrp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_frame_accepted,
    output logic                         m_frame_bad_length,
    output logic                         m_byte_dropped,
    output logic [7:0]                   m_report_b0,
    output logic [7:0]                   m_report_buttons_lo,
    output logic [7:0]                   m_report_dpad,
    output logic [7:0]                   m_report_left_x,
    output logic [7:0]                   m_report_left_y,
    output logic [7:0]                   m_report_right_x,
    output logic [7:0]                   m_report_right_y
);

    mfrp_pkg::mark_t                             marks_reg, marks_next;
    logic [mfrp_pkg::OUT_BYTES-1:0][7:0]         held_reg, held_next, held_upd;
    logic                                        m_valid_reg, m_valid_next;
    logic                                        acc_reg, acc_next;
    logic                                        bad_reg, bad_next;
    logic                                        drop_reg, drop_next;
    mfrp_pkg::seq_stat_t                         seq_stat;
    mfrp_pkg::pay_t                              payload;
    logic                                        wr_en;
    logic                                        accept;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign s_ready = seq_stat.idle && !seq_stat.done && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    mfrp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .rx_byte (s_rx_byte),
        .marks   (marks_reg),
        .stat    (seq_stat),
        .payload (payload)
    );

    always_comb begin
        case (paddr[3:2])
            mfrp_pkg::REG_START_FIRST:  prdata = {24'd0, marks_reg.start_first};
            mfrp_pkg::REG_START_SECOND: prdata = {24'd0, marks_reg.start_second};
            mfrp_pkg::REG_END_FIRST:    prdata = {24'd0, marks_reg.end_first};
            mfrp_pkg::REG_END_SECOND:   prdata = {24'd0, marks_reg.end_second};
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb begin
        marks_next = marks_reg;
        if (wr_en) begin
            case (paddr[3:2])
                mfrp_pkg::REG_START_FIRST:  marks_next.start_first  = pwdata[7:0];
                mfrp_pkg::REG_START_SECOND: marks_next.start_second = pwdata[7:0];
                mfrp_pkg::REG_END_FIRST:    marks_next.end_first    = pwdata[7:0];
                mfrp_pkg::REG_END_SECOND:   marks_next.end_second   = pwdata[7:0];
                default:                    marks_next = marks_reg;
            endcase
        end
    end

    for (genvar k = 0; k < mfrp_pkg::OUT_BYTES; k++) begin : g_rep
        if (k < mfrp_pkg::REPORT_LEN) begin : g_upd
            assign held_upd[k] = payload[k];
        end else begin : g_keep
            assign held_upd[k] = held_reg[k];
        end
    end

    always_comb begin
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        drop_next    = drop_reg;
        if (seq_stat.done) begin
            if (seq_stat.accepted) begin
                held_next = held_upd;
            end
            m_valid_next = 1'b1;
            acc_next     = seq_stat.accepted;
            bad_next     = seq_stat.bad_length;
            drop_next    = seq_stat.dropped;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg.start_first  <= mfrp_pkg::START_FIRST_RST;
            marks_reg.start_second <= mfrp_pkg::START_SECOND_RST;
            marks_reg.end_first    <= mfrp_pkg::END_FIRST_RST;
            marks_reg.end_second   <= mfrp_pkg::END_SECOND_RST;
            held_reg               <= mfrp_pkg::REPORT_RST;
            m_valid_reg            <= 1'b0;
        end else begin
            marks_reg   <= marks_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg  <= acc_next;
        bad_reg  <= bad_next;
        drop_reg <= drop_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_frame_accepted    = acc_reg;
    assign m_frame_bad_length  = bad_reg;
    assign m_byte_dropped      = drop_reg;
    assign m_report_b0         = held_reg[0];
    assign m_report_buttons_lo = held_reg[1];
    assign m_report_dpad       = held_reg[2];
    assign m_report_left_x     = held_reg[3];
    assign m_report_left_y     = held_reg[4];
    assign m_report_right_x    = held_reg[5];
    assign m_report_right_y    = held_reg[6];

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_stat.done |-> !m_valid_reg)
        else $error("Result completed while the previous transfer was pending.");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("Input ready directly after an accepted transfer.");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(seq_stat.done))
        else $error("Result appeared without a completed item.");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(acc_reg && bad_reg))
        else $error("Frame both accepted and rejected.");

endmodule
